// ===== rtl/vpc_pkg.sv =====
// package with types, constants and codes for the vram pixel plotter
`timescale 1ns / 1ps

package vpc_pkg;

  // video memory size in bytes
  localparam int unsigned VramBytes = 16384;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_PLOT       = 2'd0,
    OP_READ_PIXEL = 2'd1,
    OP_WRITE_RAW  = 2'd2,
    OP_READ_RAW   = 2'd3
  } vpc_op_e;

  // display modes
  localparam logic MODE_BITMAP = 1'b0;
  localparam logic MODE_MULTI  = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD
  } vpc_state_e;

  // input item
  typedef struct packed {
    vpc_op_e     operation;
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
    logic [3:0]  pixel_color;
    logic [13:0] mem_address;
    logic [7:0]  mem_data;
  } vpc_in_t;

  // result item
  typedef struct packed {
    logic       changed;
    logic       in_range;
    logic [3:0] color_out;
    logic [7:0] data_out;
  } vpc_out_t;

endpackage

// ===== rtl/vram_pixel_plot_with_clash.sv =====
// top level of the vram pixel plotter with two colours per bitmap cell
`timescale 1ns / 1ps

// Pixel plotter over a 16 KB video memory held as two 8 KB RAM banks: the
// lower bank keeps the pattern bytes and the upper bank the colour bytes,
// so a bitmap plot reads both bytes of a cell in one cycle and writes both
// back in the next. An item is taken when start is high and busy is low;
// each item has a RAM read cycle and then a modify and write-back cycle,
// after which busy drops and the next item may start. The result appears
// in the cycle after the write-back, for one cycle, marked by done_o, and
// must be taken then. After reset the block clears the memory, one address
// of both banks per cycle, over all 8192 addresses; busy is high during
// that pass. display_mode may be written at any time the block is idle.
module vram_pixel_plot_with_clash
  import vpc_pkg::*;
#(
  parameter int unsigned VRAM_BYTES = VramBytes
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  vpc_in_t  item_i,
  output logic     done_o,
  output vpc_out_t result_o,
  input  logic     cfg_we_i,
  input  logic     cfg_data_i
);

  localparam int unsigned BankDepth = VRAM_BYTES / 2;
  localparam int unsigned BankAw    = $clog2(BankDepth);

  vpc_state_e state_q, state_d;
  logic [BankAw-1:0] clr_cnt_q, clr_cnt_d;
  logic mode_q;

  // captured item
  vpc_op_e     op_q;
  logic [2:0]  xlo_q;
  logic [3:0]  color_q;
  logic [7:0]  mdata_q;
  logic        bank_q;
  logic        in_range_q;
  logic        item_mode_q;
  logic [BankAw-1:0] addr0_q, addr1_q;

  logic done_q;
  vpc_out_t res_q, res_d;

  logic accept;
  logic is_raw;
  logic range_d;
  logic [BankAw-1:0] pat_addr, blk_addr, raw_addr, addr0_d, addr1_d;

  logic [BankAw-1:0] ram0_addr, ram1_addr;
  logic              we0, we1;
  logic [7:0]        wd0, wd1, rd0, rd1;

  logic [7:0] mask, old_raw, npat, ncol, nb;
  logic [3:0] fg, bg, ones;
  logic       high;

  assign accept = start && !busy;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BITMAP;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // address generation from the incoming item
  assign is_raw   = (item_i.operation == OP_WRITE_RAW) || (item_i.operation == OP_READ_RAW);
  assign pat_addr = BankAw'({item_i.y_pos[7:3], item_i.x_pos[7:3], item_i.y_pos[2:0]});
  assign blk_addr = BankAw'({item_i.y_pos[7:3], item_i.x_pos[5:1], item_i.y_pos[2:0]});
  assign raw_addr = item_i.mem_address[BankAw-1:0];

  always_comb begin
    if (is_raw) begin
      range_d = 1'b1;
      addr0_d = raw_addr;
      addr1_d = raw_addr;
    end else if (mode_q == MODE_MULTI) begin
      range_d = (item_i.x_pos < 8'd64) && (item_i.y_pos < 8'd48);
      addr0_d = blk_addr;
      addr1_d = pat_addr;
    end else begin
      range_d = (item_i.y_pos < 8'd192);
      addr0_d = pat_addr;
      addr1_d = pat_addr;
    end
  end

  // item capture, mode included so a later register write cannot split an item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= item_i.operation;
      xlo_q       <= item_i.x_pos[2:0];
      color_q     <= item_i.pixel_color;
      mdata_q     <= item_i.mem_data;
      bank_q      <= item_i.mem_address[BankAw];
      in_range_q  <= range_d;
      item_mode_q <= mode_q;
      addr0_q     <= addr0_d;
      addr1_q     <= addr1_d;
    end
  end

  // next state
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // cell fields from the read data
  assign mask    = 8'h80 >> xlo_q;
  assign fg      = rd1[7:4];
  assign bg      = rd1[3:0];
  assign high    = !xlo_q[0];
  assign old_raw = bank_q ? rd1 : rd0;
  assign ones    = 4'($countones(rd0 & ~mask));
  assign nb      = high ? {color_q, rd0[3:0]} : {rd0[7:4], color_q};

  // bitmap plot: pattern and colour update
  always_comb begin
    npat = rd0;
    ncol = rd1;
    if (color_q == fg) begin
      npat = rd0 | mask;
    end else if ((color_q == bg) || (color_q == 4'd0)) begin
      npat = rd0 & ~mask;
    end else if (ones <= 4'd3) begin
      ncol = {color_q, bg};
      npat = rd0 | mask;
    end else begin
      ncol = {fg, color_q};
      npat = rd0 & ~mask;
    end
  end

  // outputs of the sequencer: ram ports and result
  always_comb begin
    we0       = 1'b0;
    we1       = 1'b0;
    wd0       = '0;
    wd1       = '0;
    ram0_addr = addr0_d;
    ram1_addr = addr1_d;
    res_d     = '0;
    unique case (state_q)
      ST_CLEAR: begin
        we0       = 1'b1;
        we1       = 1'b1;
        ram0_addr = clr_cnt_q;
        ram1_addr = clr_cnt_q;
      end
      ST_IDLE: begin
      end
      ST_MOD: begin
        ram0_addr      = addr0_q;
        ram1_addr      = addr1_q;
        res_d.in_range = in_range_q;
        unique case (op_q)
          OP_WRITE_RAW: begin
            we0           = !bank_q;
            we1           = bank_q;
            wd0           = mdata_q;
            wd1           = mdata_q;
            res_d.changed = (old_raw != mdata_q);
          end
          OP_READ_RAW: begin
            res_d.data_out = old_raw;
          end
          OP_PLOT: begin
            if (in_range_q) begin
              if (item_mode_q == MODE_MULTI) begin
                we0           = 1'b1;
                wd0           = nb;
                res_d.changed = (nb != rd0);
              end else begin
                we0           = 1'b1;
                we1           = 1'b1;
                wd0           = npat;
                wd1           = ncol;
                res_d.changed = (npat != rd0) || (ncol != rd1);
              end
            end
          end
          OP_READ_PIXEL: begin
            if (in_range_q) begin
              if (item_mode_q == MODE_MULTI) begin
                res_d.color_out = high ? rd0[7:4] : rd0[3:0];
              end else begin
                res_d.color_out = ((rd0 & mask) != 8'd0) ? fg : bg;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == ST_MOD);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MOD) begin
      res_q <= res_d;
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  // pattern bank
  vpc_ram #(
    .Width(8),
    .Depth(BankDepth)
  ) u_ram_lo (
    .clk_i  (clk_i),
    .we_i   (we0),
    .addr_i (ram0_addr),
    .wdata_i(wd0),
    .rdata_o(rd0)
  );

  // colour bank
  vpc_ram #(
    .Width(8),
    .Depth(BankDepth)
  ) u_ram_hi (
    .clk_i  (clk_i),
    .we_i   (we1),
    .addr_i (ram1_addr),
    .wdata_i(wd1),
    .rdata_o(rd1)
  );

  // a result follows exactly one write-back cycle
  a_done_after_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_MOD))
    else $error("result without write-back cycle");

  // an accepted item goes straight to the write-back cycle
  a_accept_to_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_MOD))
    else $error("accepted item not processed");

  // write-back is always followed by the idle state
  a_mod_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) |=> (state_q == ST_IDLE))
    else $error("write-back longer than one cycle");

  // off-screen coordinates leave memory untouched
  a_no_write_off_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MOD) && !in_range_q) |-> (!we0 && !we1))
    else $error("memory written for off-screen pixel");

  // reads never write memory
  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MOD) && ((op_q == OP_READ_RAW) || (op_q == OP_READ_PIXEL)))
      |-> (!we0 && !we1))
    else $error("memory written on a read");

endmodule

// ===== rtl/vpc_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps

module vpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write and registered read on one port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
